// ===== sv/mwfs_pkg.sv =====
package mwfs_pkg;

  // Field widths
  localparam int PWM_W    = 7;
  localparam int PHASE_W  = 4;
  localparam int TIMER_W  = 11;
  localparam int MISS_W   = 6;
  localparam int RANGE_W  = 12;
  localparam int TICKS_W  = 10;
  localparam int CAD_W    = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [PWM_W-1:0]  PWM_MAX  = 7'd99;
  localparam logic [MISS_W-1:0] MISS_MAX = 6'd63;

  // Fixed phase durations in ticks
  localparam logic [TIMER_W-1:0] START_DELAY_TICKS = 11'd30;
  localparam logic [TIMER_W-1:0] PAUSE_TICKS       = 11'd10;
  localparam logic [TIMER_W-1:0] SETTLE_TICKS      = 11'd15;
  localparam logic [TIMER_W-1:0] HALF_SETTLE_TICKS = 11'd20;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_WAIT          = 4'd0;
  localparam logic [PHASE_W-1:0] PH_START_DELAY   = 4'd1;
  localparam logic [PHASE_W-1:0] PH_CRUISE        = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SKIP          = 4'd3;
  localparam logic [PHASE_W-1:0] PH_DEAD_PAUSE    = 4'd4;
  localparam logic [PHASE_W-1:0] PH_HALF_TURN     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_HALF_SETTLE   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_GAP_PAUSE     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_APPROACH      = 4'd8;
  localparam logic [PHASE_W-1:0] PH_APPR_SETTLE   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_MIN_SPIN      = 4'd10;
  localparam logic [PHASE_W-1:0] PH_POLL_SPIN     = 4'd11;
  localparam logic [PHASE_W-1:0] PH_SPIN_SETTLE   = 4'd12;
  localparam logic [PHASE_W-1:0] PH_BRIDGE        = 4'd13;
  localparam logic [PHASE_W-1:0] PH_BRIDGE_SETTLE = 4'd14;
  localparam logic [PHASE_W-1:0] PH_UNUSED        = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_DUTY   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_OFFSET  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_DUTY     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_SPEED = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_RANGE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE        = 4'd7;

  typedef struct packed {
    logic [PWM_W-1:0] lf;
    logic [PWM_W-1:0] lr;
    logic [PWM_W-1:0] rf;
    logic [PWM_W-1:0] rr;
  } drive_t;

  localparam drive_t DRIVE_OFF = '0;

  typedef struct packed {
    logic [PWM_W-1:0]   cruise_duty;
    logic [MISS_W-1:0]  steer_offset;
    logic [PWM_W-1:0]   spin_duty;
    logic [PWM_W-1:0]   reverse_speed;
    logic [MISS_W-1:0]  gap_threshold;
    logic [RANGE_W-1:0] stop_range;
    logic [TICKS_W-1:0] half_turn_ticks;
    logic [TICKS_W-1:0] bridge_ticks;
  } cfg_t;

  typedef struct packed {
    logic               left_wall;
    logic               right_wall;
    logic [RANGE_W-1:0] front_mm;
    logic               start_key;
  } item_t;

  typedef struct packed {
    drive_t             drive;
    logic [PHASE_W-1:0] phase;
  } result_t;

  // Saturate a signed duty to 0..99
  function automatic logic [PWM_W-1:0] clamp_pwm(input logic signed [8:0] v);
    logic [PWM_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 9'sd99) begin
      r = PWM_MAX;
    end else begin
      r = v[PWM_W-1:0];
    end
    return r;
  endfunction

  function automatic drive_t fwd(input logic signed [8:0] l, input logic signed [8:0] r);
    drive_t d;
    d    = DRIVE_OFF;
    d.lf = clamp_pwm(l);
    d.rf = clamp_pwm(r);
    return d;
  endfunction

  // Spin in place; clockwise runs left forward and right reverse
  function automatic drive_t spin(input logic cw, input logic [PWM_W-1:0] pwm);
    drive_t d;
    logic [PWM_W-1:0] p;
    p = (pwm > PWM_MAX) ? PWM_MAX : pwm;
    d = DRIVE_OFF;
    if (cw) begin
      d.lf = p;
      d.rr = p;
    end else begin
      d.lr = p;
      d.rf = p;
    end
    return d;
  endfunction

endpackage

// ===== sv/mwfs_in_if.sv =====
interface mwfs_in_if import mwfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               left_wall;
  logic               right_wall;
  logic [RANGE_W-1:0] front_mm;
  logic               start_key;

  modport source (output valid, left_wall, right_wall, front_mm, start_key, input ready);
  modport sink   (input valid, left_wall, right_wall, front_mm, start_key, output ready);
endinterface

// ===== sv/mwfs_out_if.sv =====
interface mwfs_out_if import mwfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PWM_W-1:0]   left_forward_pwm;
  logic [PWM_W-1:0]   left_reverse_pwm;
  logic [PWM_W-1:0]   right_forward_pwm;
  logic [PWM_W-1:0]   right_reverse_pwm;
  logic [PHASE_W-1:0] phase_code;

  modport source (output valid, left_forward_pwm, left_reverse_pwm, right_forward_pwm,
                  right_reverse_pwm, phase_code, input ready);
  modport sink   (input valid, left_forward_pwm, left_reverse_pwm, right_forward_pwm,
                  right_reverse_pwm, phase_code, output ready);
endinterface

// ===== sv/mwfs_cfg_if.sv =====
interface mwfs_cfg_if import mwfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mwfs_cfg_regs.sv =====
module mwfs_cfg_regs import mwfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mwfs_cfg_if.sink cfg,
  output cfg_t  regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.cruise_duty     <= 7'd60;
      regs.steer_offset    <= 6'd8;
      regs.spin_duty       <= 7'd45;
      regs.reverse_speed   <= 7'd60;
      regs.gap_threshold   <= 6'd7;
      regs.stop_range      <= 12'd100;
      regs.half_turn_ticks <= 10'd150;
      regs.bridge_ticks    <= 10'd110;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CRUISE_DUTY:   regs.cruise_duty     <= cfg.data[PWM_W-1:0];
        CFG_STEER_OFFSET:  regs.steer_offset    <= cfg.data[MISS_W-1:0];
        CFG_SPIN_DUTY:     regs.spin_duty       <= cfg.data[PWM_W-1:0];
        CFG_REVERSE_SPEED: regs.reverse_speed   <= cfg.data[PWM_W-1:0];
        CFG_GAP_THRESHOLD: regs.gap_threshold   <= cfg.data[MISS_W-1:0];
        CFG_STOP_RANGE:    regs.stop_range      <= cfg.data[RANGE_W-1:0];
        CFG_HALF_TURN:     regs.half_turn_ticks <= cfg.data[TICKS_W-1:0];
        CFG_BRIDGE:        regs.bridge_ticks    <= cfg.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mwfs_core.sv =====
module mwfs_core import mwfs_pkg::*; #(
  parameter int CRUISE_PERIOD_TICKS = 3,
  parameter int MIN_SPIN_TICKS      = 25,
  parameter int SPIN_TIMEOUT_TICKS  = 220,
  parameter int APPROACH_TICKS      = 80
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    regs,
  output result_t res
);

  localparam logic [CAD_W-1:0]   CAD_LAST     = CAD_W'(CRUISE_PERIOD_TICKS - 1);
  localparam logic [TIMER_W-1:0] MIN_SPIN_DUR = TIMER_W'(MIN_SPIN_TICKS);
  localparam logic [TIMER_W-1:0] TIMEOUT_DUR  = TIMER_W'(SPIN_TIMEOUT_TICKS);
  localparam logic [TIMER_W-1:0] APPROACH_DUR = TIMER_W'(APPROACH_TICKS);

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIMER_W-1:0] timer;
    logic [MISS_W-1:0]  rmiss;
    logic [MISS_W-1:0]  lmiss;
    logic               skip;
    logic               cw;
    logic               second;
    logic [CAD_W-1:0]   cad;
    drive_t             drive;
  } state_t;

  state_t cur;
  state_t cur_next;

  logic [TIMER_W-1:0] timer_inc;
  logic [CAD_W-1:0]   cad_inc;
  logic               dead_end;
  logic               right_gap;
  logic               left_gap;
  logic [MISS_W-1:0]  miss_sel;
  logic [MISS_W-1:0]  miss_inc;
  logic               gap_hit;
  logic signed [8:0]  b;
  logic signed [8:0]  o;
  logic [TIMER_W-1:0] half_dur;
  logic [TIMER_W-1:0] bridge_dur;

  // Shared decode of the current tick
  always_comb begin
    timer_inc  = cur.timer + 1'b1;
    cad_inc    = (cur.cad == CAD_LAST) ? '0 : cur.cad + 1'b1;
    b          = $signed({2'b00, regs.cruise_duty});
    o          = $signed({3'b000, regs.steer_offset});
    half_dur   = TIMER_W'(regs.half_turn_ticks);
    bridge_dur = TIMER_W'(regs.bridge_ticks);
    dead_end   = (item.front_mm != '0) && (item.front_mm < regs.stop_range);
    right_gap  = !item.right_wall && item.left_wall;
    left_gap   = item.right_wall && !item.left_wall;
    miss_sel   = right_gap ? cur.rmiss : cur.lmiss;
    miss_inc   = (miss_sel < MISS_MAX) ? miss_sel + 1'b1 : miss_sel;
    gap_hit    = miss_inc >= regs.gap_threshold;
  end

  // Phase sequencer next state
  always_comb begin
    cur_next = cur;
    unique case (cur.phase)
      PH_WAIT: begin
        if (item.start_key) begin
          cur_next.phase = PH_START_DELAY;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
        end
      end
      PH_START_DELAY: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= START_DELAY_TICKS) begin
          cur_next.phase = PH_CRUISE;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
          cur_next.cad   = '0;
          cur_next.rmiss = '0;
          cur_next.lmiss = '0;
        end
      end
      PH_CRUISE: begin
        if (cur.cad == '0) begin
          if (dead_end) begin
            cur_next.skip  = 1'b1;
            cur_next.rmiss = '0;
            cur_next.lmiss = '0;
            cur_next.phase = PH_DEAD_PAUSE;
            cur_next.timer = '0;
            cur_next.drive = DRIVE_OFF;
          end else if (right_gap || left_gap) begin
            // Verify the gap by counting misses on that side
            if (right_gap) begin
              cur_next.lmiss = '0;
              cur_next.rmiss = gap_hit ? '0 : miss_inc;
            end else begin
              cur_next.rmiss = '0;
              cur_next.lmiss = gap_hit ? '0 : miss_inc;
            end
            if (gap_hit) begin
              if (cur.skip) begin
                cur_next.skip  = 1'b0;
                cur_next.phase = PH_SKIP;
                cur_next.drive = fwd(b, b);
              end else begin
                cur_next.cw     = right_gap;
                cur_next.second = 1'b0;
                cur_next.phase  = PH_GAP_PAUSE;
                cur_next.timer  = '0;
                cur_next.drive  = DRIVE_OFF;
              end
            end else if (right_gap) begin
              cur_next.drive = fwd(b + o, b - o);
            end else begin
              cur_next.drive = fwd(b - o, b + o);
            end
          end else begin
            cur_next.rmiss = '0;
            cur_next.lmiss = '0;
            cur_next.drive = fwd(b, b);
          end
        end
        if (cur_next.phase == PH_CRUISE || cur_next.phase == PH_SKIP) begin
          cur_next.cad = cad_inc;
        end
      end
      PH_SKIP: begin
        if (cur.cad == '0) begin
          cur_next.drive = fwd(b, b);
          if (item.left_wall && item.right_wall) begin
            cur_next.phase = PH_CRUISE;
            cur_next.rmiss = '0;
            cur_next.lmiss = '0;
          end
        end
        cur_next.cad = cad_inc;
      end
      PH_DEAD_PAUSE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= PAUSE_TICKS) begin
          cur_next.phase = PH_HALF_TURN;
          cur_next.timer = '0;
          cur_next.drive = spin(1'b1, regs.reverse_speed);
        end
      end
      PH_HALF_TURN: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= half_dur) begin
          cur_next.phase = PH_HALF_SETTLE;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
        end
      end
      PH_HALF_SETTLE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= HALF_SETTLE_TICKS) begin
          cur_next.phase = PH_CRUISE;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
          cur_next.cad   = '0;
          cur_next.rmiss = '0;
          cur_next.lmiss = '0;
        end
      end
      PH_GAP_PAUSE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= PAUSE_TICKS) begin
          cur_next.phase = PH_APPROACH;
          cur_next.timer = '0;
          cur_next.drive = fwd(b, b);
        end
      end
      PH_APPROACH: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= APPROACH_DUR) begin
          cur_next.phase = PH_APPR_SETTLE;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
        end
      end
      PH_APPR_SETTLE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= PAUSE_TICKS) begin
          cur_next.phase = PH_MIN_SPIN;
          cur_next.timer = '0;
          cur_next.drive = spin(cur.cw, regs.spin_duty);
        end
      end
      PH_MIN_SPIN: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= MIN_SPIN_DUR) begin
          cur_next.phase = PH_POLL_SPIN;
          cur_next.timer = '0;
          cur_next.drive = spin(cur.cw, regs.spin_duty);
        end
      end
      PH_POLL_SPIN: begin
        // Stop on both walls seen, else on timeout
        if (item.left_wall && item.right_wall) begin
          cur_next.phase = PH_SPIN_SETTLE;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
        end else begin
          cur_next.timer = timer_inc;
          if (timer_inc >= TIMEOUT_DUR) begin
            cur_next.phase = PH_SPIN_SETTLE;
            cur_next.timer = '0;
            cur_next.drive = DRIVE_OFF;
          end
        end
      end
      PH_SPIN_SETTLE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= SETTLE_TICKS) begin
          cur_next.timer = '0;
          if (cur.second) begin
            cur_next.second = 1'b0;
            cur_next.phase  = PH_CRUISE;
            cur_next.drive  = DRIVE_OFF;
            cur_next.cad    = '0;
            cur_next.rmiss  = '0;
            cur_next.lmiss  = '0;
          end else begin
            cur_next.phase = PH_BRIDGE;
            cur_next.drive = fwd(b, b);
          end
        end
      end
      PH_BRIDGE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= bridge_dur) begin
          cur_next.phase = PH_BRIDGE_SETTLE;
          cur_next.timer = '0;
          cur_next.drive = DRIVE_OFF;
        end
      end
      PH_BRIDGE_SETTLE: begin
        cur_next.timer = timer_inc;
        if (timer_inc >= SETTLE_TICKS) begin
          cur_next.second = 1'b1;
          cur_next.phase  = PH_MIN_SPIN;
          cur_next.timer  = '0;
          cur_next.drive  = spin(cur.cw, regs.spin_duty);
        end
      end
      default: begin
        cur_next.phase = PH_WAIT;
        cur_next.timer = '0;
        cur_next.drive = DRIVE_OFF;
      end
    endcase
  end

  // State register, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (step_en) begin
      cur <= cur_next;
    end
  end

  assign res.drive = cur_next.drive;
  assign res.phase = cur_next.phase;

  a_cad_range: assert property (@(posedge clk) disable iff (rst)
    cur.cad <= CAD_LAST)
    else $error("cadence count out of range");

  a_no_unused_phase: assert property (@(posedge clk) disable iff (rst)
    cur.phase != PH_UNUSED)
    else $error("unused phase reached");

  a_idle_motors_off: assert property (@(posedge clk) disable iff (rst)
    (cur.phase == PH_WAIT || cur.phase == PH_START_DELAY) |-> cur.drive == DRIVE_OFF)
    else $error("motors driven while waiting for start");

endmodule

// ===== sv/maze_wall_follow_sequencer.sv =====
// An accepted tick waits in the input register, then steps into the result register that
// drives the output channel. Throughput: one tick per cycle while the motor side is ready;
// the step logic sits between them; input frees when the result register can load.
// Reset (rst, synchronous): phase wait, all counters clear, motors off, pipeline
// empty, configuration registers back to their power-on values.
module maze_wall_follow_sequencer import mwfs_pkg::*; #(
  parameter int CRUISE_PERIOD_TICKS = 3,
  parameter int MIN_SPIN_TICKS      = 25,
  parameter int SPIN_TIMEOUT_TICKS  = 220,
  parameter int APPROACH_TICKS      = 80
) (
  input  logic       clk,
  input  logic       rst,
  mwfs_in_if.sink    sensor,
  mwfs_out_if.source motor,
  mwfs_cfg_if.sink   cfg
);

  cfg_t    regs;
  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    adv;
  logic    step_en;

  mwfs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake flow
  assign adv          = !out_valid || motor.ready;
  assign step_en      = s1_valid && adv;
  assign sensor.ready = !s1_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sensor.valid && sensor.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sensor.valid && sensor.ready) begin
      s1_item.left_wall  <= sensor.left_wall;
      s1_item.right_wall <= sensor.right_wall;
      s1_item.front_mm   <= sensor.front_mm;
      s1_item.start_key  <= sensor.start_key;
    end
  end

  mwfs_core #(
    .CRUISE_PERIOD_TICKS (CRUISE_PERIOD_TICKS),
    .MIN_SPIN_TICKS      (MIN_SPIN_TICKS),
    .SPIN_TIMEOUT_TICKS  (SPIN_TIMEOUT_TICKS),
    .APPROACH_TICKS      (APPROACH_TICKS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (s1_item),
    .regs    (regs),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (motor.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res <= res;
    end
  end

  assign motor.valid             = out_valid;
  assign motor.left_forward_pwm  = out_res.drive.lf;
  assign motor.left_reverse_pwm  = out_res.drive.lr;
  assign motor.right_forward_pwm = out_res.drive.rf;
  assign motor.right_reverse_pwm = out_res.drive.rr;
  assign motor.phase_code        = out_res.phase;

  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    step_en |=> out_valid)
    else $error("stepped tick did not reach the result register");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.drive.lf <= PWM_MAX) && (out_res.drive.lr <= PWM_MAX) &&
                  (out_res.drive.rf <= PWM_MAX) && (out_res.drive.rr <= PWM_MAX))
    else $error("duty above limit");

  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.drive.lf == '0 || out_res.drive.lr == '0) &&
                  (out_res.drive.rf == '0 || out_res.drive.rr == '0))
    else $error("wheel driven forward and reverse at once");

endmodule

// ===== test/tb_maze_wall_follow_sequencer.sv =====
`timescale 1ns / 100ps

module tb_maze_wall_follow_sequencer;
  import mwfs_pkg::*;

  // Fixed timing of the block as built (default parameters)
  localparam int CRUISE_TICKS  = 3;
  localparam int SPIN_MIN      = 25;
  localparam int SPIN_TIMEOUT  = 220;
  localparam int APPROACH_RUN  = 80;
  localparam int SETTING_COUNT = 5;
  localparam int TICKS_PER_SETTING = 120;

  logic clk = 1'b0;
  logic rst;

  mwfs_in_if  sensor_if ();
  mwfs_out_if motor_if ();
  mwfs_cfg_if cfg_if ();

  maze_wall_follow_sequencer DUT (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor_if),
    .motor  (motor_if),
    .cfg    (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sensor ticks waiting to be sent, motor commands still due
  item_t   tick_queue[$];
  result_t motor_cmd_q[$];
  item_t   shown_tick;
  item_t   next_tick;
  result_t next_cmd;
  result_t due_cmd;

  int ticks_queued = 0;
  int ticks_sent   = 0;
  int mismatch_count = 0;
  int tick_gap_max = 0;
  int motor_stall_max = 0;
  int tick_wait;
  int motor_hold;
  int stall_draw;
  logic tick_moved;
  logic motor_moved;

  // Sequencer copy: configuration and state
  cfg_t               seq_cfg;
  logic [PHASE_W-1:0] ph;
  logic [TIMER_W-1:0] ph_timer;
  logic [MISS_W-1:0]  r_miss;
  logic [MISS_W-1:0]  l_miss;
  logic               skip_pend;
  logic               turn_cw;
  logic               second_pass;
  logic [CAD_W-1:0]   cadence;
  drive_t             held;

  // ---------------------------------------------------------------- sequencer copy

  function automatic logic [PWM_W-1:0] sat_duty(input int v);
    if (v < 0) return '0;
    if (v > 99) return 7'd99;
    return v[PWM_W-1:0];
  endfunction

  function automatic drive_t straight(input int l, input int r);
    drive_t d;
    d = DRIVE_OFF;
    d.lf = sat_duty(l);
    d.rf = sat_duty(r);
    return d;
  endfunction

  // Clockwise: left wheel forward, right wheel reverse
  function automatic drive_t pivot(input logic cw, input int duty);
    drive_t d;
    d = DRIVE_OFF;
    if (cw) begin
      d.lf = sat_duty(duty);
      d.rr = sat_duty(duty);
    end else begin
      d.lr = sat_duty(duty);
      d.rf = sat_duty(duty);
    end
    return d;
  endfunction

  task automatic go_phase(input logic [PHASE_W-1:0] p, input drive_t d);
    ph = p;
    ph_timer = '0;
    held = d;
  endtask

  task automatic go_cruise();
    go_phase(PH_CRUISE, DRIVE_OFF);
    cadence = '0;
    r_miss = '0;
    l_miss = '0;
  endtask

  // Advance the phase timer; true once the duration is used up
  function automatic bit count_tick(input int dur);
    ph_timer = ph_timer + 11'd1;
    return int'(ph_timer) >= dur;
  endfunction

  // One side missing: steer toward it until the gap is confirmed
  task automatic side_gap(inout logic [MISS_W-1:0] miss, inout logic [MISS_W-1:0] other,
                          input logic cw);
    int b;
    int o;
    b = int'(seq_cfg.cruise_duty);
    o = int'(seq_cfg.steer_offset);
    other = '0;
    if (miss != MISS_MAX) miss = miss + 6'd1;
    if (miss >= seq_cfg.gap_threshold) begin
      miss = '0;
      if (skip_pend) begin
        // first gap after a dead end is driven straight through
        skip_pend = 1'b0;
        ph = PH_SKIP;
        held = straight(b, b);
      end else begin
        turn_cw = cw;
        second_pass = 1'b0;
        go_phase(PH_GAP_PAUSE, DRIVE_OFF);
      end
    end else begin
      held = cw ? straight(b + o, b - o) : straight(b - o, b + o);
    end
  endtask

  task automatic cruise_decision(input item_t t);
    int b;
    b = int'(seq_cfg.cruise_duty);
    if (t.front_mm > 0 && t.front_mm < seq_cfg.stop_range) begin
      skip_pend = 1'b1;
      r_miss = '0;
      l_miss = '0;
      go_phase(PH_DEAD_PAUSE, DRIVE_OFF);
    end else if (!t.right_wall && t.left_wall) begin
      side_gap(r_miss, l_miss, 1'b1);
    end else if (t.right_wall && !t.left_wall) begin
      side_gap(l_miss, r_miss, 1'b0);
    end else begin
      r_miss = '0;
      l_miss = '0;
      held = straight(b, b);
    end
  endtask

  task automatic advance_sequencer(input item_t t, output result_t r);
    int b;
    int ts;
    b  = int'(seq_cfg.cruise_duty);
    ts = int'(seq_cfg.spin_duty);
    case (ph)
      PH_WAIT: begin
        if (t.start_key) go_phase(PH_START_DELAY, DRIVE_OFF);
      end
      PH_START_DELAY: begin
        if (count_tick(int'(START_DELAY_TICKS))) go_cruise();
      end
      PH_CRUISE: begin
        if (cadence == 0) cruise_decision(t);
        if (ph == PH_CRUISE || ph == PH_SKIP)
          cadence = CAD_W'((int'(cadence) + 1) % CRUISE_TICKS);
      end
      PH_SKIP: begin
        // front range ignored until both walls come back
        if (cadence == 0) begin
          held = straight(b, b);
          if (t.left_wall && t.right_wall) begin
            ph = PH_CRUISE;
            r_miss = '0;
            l_miss = '0;
          end
        end
        cadence = CAD_W'((int'(cadence) + 1) % CRUISE_TICKS);
      end
      PH_DEAD_PAUSE: begin
        if (count_tick(int'(PAUSE_TICKS)))
          go_phase(PH_HALF_TURN, pivot(1'b1, int'(seq_cfg.reverse_speed)));
      end
      PH_HALF_TURN: begin
        if (count_tick(int'(seq_cfg.half_turn_ticks))) go_phase(PH_HALF_SETTLE, DRIVE_OFF);
      end
      PH_HALF_SETTLE: begin
        if (count_tick(int'(HALF_SETTLE_TICKS))) go_cruise();
      end
      PH_GAP_PAUSE: begin
        if (count_tick(int'(PAUSE_TICKS))) go_phase(PH_APPROACH, straight(b, b));
      end
      PH_APPROACH: begin
        if (count_tick(APPROACH_RUN)) go_phase(PH_APPR_SETTLE, DRIVE_OFF);
      end
      PH_APPR_SETTLE: begin
        if (count_tick(int'(PAUSE_TICKS))) go_phase(PH_MIN_SPIN, pivot(turn_cw, ts));
      end
      PH_MIN_SPIN: begin
        if (count_tick(SPIN_MIN)) go_phase(PH_POLL_SPIN, pivot(turn_cw, ts));
      end
      PH_POLL_SPIN: begin
        if (t.left_wall && t.right_wall) go_phase(PH_SPIN_SETTLE, DRIVE_OFF);
        else if (count_tick(SPIN_TIMEOUT)) go_phase(PH_SPIN_SETTLE, DRIVE_OFF);
      end
      PH_SPIN_SETTLE: begin
        if (count_tick(int'(SETTLE_TICKS))) begin
          if (second_pass) begin
            second_pass = 1'b0;
            go_cruise();
          end else begin
            go_phase(PH_BRIDGE, straight(b, b));
          end
        end
      end
      PH_BRIDGE: begin
        if (count_tick(int'(seq_cfg.bridge_ticks))) go_phase(PH_BRIDGE_SETTLE, DRIVE_OFF);
      end
      PH_BRIDGE_SETTLE: begin
        if (count_tick(int'(SETTLE_TICKS))) begin
          second_pass = 1'b1;
          go_phase(PH_MIN_SPIN, pivot(turn_cw, ts));
        end
      end
      default: begin
        go_phase(PH_WAIT, DRIVE_OFF);
      end
    endcase
    r.drive = held;
    r.phase = ph;
  endtask

  // ---------------------------------------------------------------- sensor driver

  always @(negedge clk) begin
    if (rst) begin
      sensor_if.valid <= 1'b0;
      tick_wait <= 0;
    end else if (!sensor_if.valid || tick_moved) begin
      if (tick_wait > 0) begin
        sensor_if.valid <= 1'b0;
        tick_wait <= tick_wait - 1;
      end else if (tick_queue.size() > 0) begin
        next_tick = tick_queue.pop_front();
        shown_tick <= next_tick;
        sensor_if.valid      <= 1'b1;
        sensor_if.left_wall  <= next_tick.left_wall;
        sensor_if.right_wall <= next_tick.right_wall;
        sensor_if.front_mm   <= next_tick.front_mm;
        sensor_if.start_key  <= next_tick.start_key;
        tick_wait <= int'($urandom_range(0, tick_gap_max));
      end else begin
        sensor_if.valid <= 1'b0;
      end
    end
  end

  // Accepted tick: run the sequencer copy and queue the command it gives
  always @(posedge clk) begin
    if (rst) begin
      tick_moved <= 1'b0;
    end else begin
      tick_moved <= sensor_if.valid && sensor_if.ready;
      if (sensor_if.valid && sensor_if.ready) begin
        advance_sequencer(shown_tick, next_cmd);
        motor_cmd_q.push_back(next_cmd);
        ticks_sent++;
      end
    end
  end

  // ---------------------------------------------------------------- motor monitor

  always @(negedge clk) begin
    if (rst) begin
      motor_if.ready <= 1'b0;
      motor_hold <= 0;
    end else if (motor_moved) begin
      stall_draw = int'($urandom_range(0, motor_stall_max));
      motor_if.ready <= (stall_draw == 0);
      motor_hold <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (motor_hold > 0) begin
      motor_if.ready <= 1'b0;
      motor_hold <= motor_hold - 1;
    end else begin
      motor_if.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      motor_moved <= 1'b0;
    end else begin
      motor_moved <= motor_if.valid && motor_if.ready;
      if (motor_if.valid && motor_if.ready) begin
        if (motor_cmd_q.size() == 0) begin
          $display("%0t: motor transaction expected none actual phase %0d", $time,
                   motor_if.phase_code);
          mismatch_count++;
        end else begin
          due_cmd = motor_cmd_q.pop_front();
          check_field("left_forward_pwm", int'(due_cmd.drive.lf),
                      int'(motor_if.left_forward_pwm));
          check_field("left_reverse_pwm", int'(due_cmd.drive.lr),
                      int'(motor_if.left_reverse_pwm));
          check_field("right_forward_pwm", int'(due_cmd.drive.rf),
                      int'(motor_if.right_forward_pwm));
          check_field("right_reverse_pwm", int'(due_cmd.drive.rr),
                      int'(motor_if.right_reverse_pwm));
          check_field("phase_code", int'(due_cmd.phase), int'(motor_if.phase_code));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_CRUISE_DUTY:   seq_cfg.cruise_duty     = val[PWM_W-1:0];
      CFG_STEER_OFFSET:  seq_cfg.steer_offset    = val[MISS_W-1:0];
      CFG_SPIN_DUTY:     seq_cfg.spin_duty       = val[PWM_W-1:0];
      CFG_REVERSE_SPEED: seq_cfg.reverse_speed   = val[PWM_W-1:0];
      CFG_GAP_THRESHOLD: seq_cfg.gap_threshold   = val[MISS_W-1:0];
      CFG_STOP_RANGE:    seq_cfg.stop_range      = val[RANGE_W-1:0];
      CFG_HALF_TURN:     seq_cfg.half_turn_ticks = val[TICKS_W-1:0];
      CFG_BRIDGE:        seq_cfg.bridge_ticks    = val[TICKS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int base, input int steer, input int turn, input int rev,
                           input int gap, input int stop_mm, input int half, input int bridge);
    write_reg(CFG_CRUISE_DUTY, base);
    write_reg(CFG_STEER_OFFSET, steer);
    write_reg(CFG_SPIN_DUTY, turn);
    write_reg(CFG_REVERSE_SPEED, rev);
    write_reg(CFG_GAP_THRESHOLD, gap);
    write_reg(CFG_STOP_RANGE, stop_mm);
    write_reg(CFG_HALF_TURN, half);
    write_reg(CFG_BRIDGE, bridge);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_tick(input logic lw, input logic rw, input int front, input logic key);
    item_t t;
    t.left_wall  = lw;
    t.right_wall = rw;
    t.front_mm   = front[RANGE_W-1:0];
    t.start_key  = key;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  function automatic int far_reading();
    if ($urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(int'(seq_cfg.stop_range), 4000));
  endfunction

  function automatic int near_reading();
    if (seq_cfg.stop_range < 2) return 1;
    return int'($urandom_range(1, int'(seq_cfg.stop_range) - 1));
  endfunction

  // One stretch of maze: walls on both sides, side gaps of random length,
  // dead ends, and some noise in between
  task automatic queue_stretch();
    int kind;
    int len;
    int k;
    logic key;
    kind = int'($urandom_range(0, 99));
    len  = int'($urandom_range(2, 30));
    for (k = 0; k < len; k++) begin
      key = ($urandom_range(0, 7) == 0);
      if (kind < 40) begin
        push_tick(1'b1, 1'b1, far_reading(), key);
      end else if (kind < 55) begin
        push_tick(1'b1, 1'b0, far_reading(), key);
      end else if (kind < 70) begin
        push_tick(1'b0, 1'b1, far_reading(), key);
      end else if (kind < 78) begin
        push_tick(1'b0, 1'b0, far_reading(), key);
      end else if (kind < 86) begin
        push_tick(1'b1, 1'b1, (k < 3) ? near_reading() : far_reading(), key);
      end else begin
        push_tick(($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                  int'($urandom_range(0, 4000)), key);
      end
    end
  endtask

  // Hold the sender until every queued tick has its command back
  task automatic drain();
    while (ticks_sent != ticks_queued || motor_cmd_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int s;
    int stop_at;
    rst = 1'b1;
    sensor_if.valid = 1'b0;
    sensor_if.left_wall = 1'b0;
    sensor_if.right_wall = 1'b0;
    sensor_if.front_mm = '0;
    sensor_if.start_key = 1'b0;
    motor_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    seq_cfg.cruise_duty     = 7'd60;
    seq_cfg.steer_offset    = 6'd8;
    seq_cfg.spin_duty       = 7'd45;
    seq_cfg.reverse_speed   = 7'd60;
    seq_cfg.gap_threshold   = 6'd7;
    seq_cfg.stop_range      = 12'd100;
    seq_cfg.half_turn_ticks = 10'd150;
    seq_cfg.bridge_ticks    = 10'd110;
    ph = PH_WAIT;
    ph_timer = '0;
    r_miss = '0;
    l_miss = '0;
    skip_pend = 1'b0;
    turn_cw = 1'b0;
    second_pass = 1'b0;
    cadence = '0;
    held = DRIVE_OFF;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (s = 0; s < SETTING_COUNT; s++) begin
      drain();
      case (s)
        0: begin
          write_all(60, 8, 45, 60, 2, 100, 4, 3);
          tick_gap_max = 11;
          motor_stall_max = 11;
        end
        1: begin
          // top duties, gap threshold of one, zero half-turn and bridge durations
          write_all(99, 49, 99, 99, 1, 4000, 0, 0);
          tick_gap_max = 0;
          motor_stall_max = 0;
        end
        2: begin
          // zero duties, gap threshold and stop range; gap confirmed on the first missing decision
          write_all(0, 49, 0, 0, 0, 0, 1, 1);
          tick_gap_max = 11;
          motor_stall_max = 0;
        end
        3: begin
          // duties past 99 saturate; longest timed phases
          write_all(127, 30, 127, 127, 63, 1500, 1023, 1023);
          tick_gap_max = 0;
          motor_stall_max = 11;
        end
        default: begin
          write_all($urandom_range(0, 99), $urandom_range(0, 49), $urandom_range(0, 99),
                    $urandom_range(0, 99), $urandom_range(1, 10), $urandom_range(50, 2000),
                    $urandom_range(0, 40), $urandom_range(0, 40));
          tick_gap_max = 11;
          motor_stall_max = 11;
        end
      endcase

      if (s == 0) begin
        // waiting for the start key, then the start delay with odd readings
        push_tick(1'b0, 1'b0, 0, 1'b0);
        push_tick(1'b1, 1'b1, 4000, 1'b0);
        push_tick(1'b1, 1'b0, 1, 1'b0);
        push_tick(1'b0, 1'b1, 2047, 1'b0);
        push_tick(1'b1, 1'b1, 4000, 1'b1);
        push_tick(1'b0, 1'b0, 0, 1'b1);
        push_tick(1'b1, 1'b1, 1, 1'b0);
        push_tick(1'b0, 1'b1, 4000, 1'b0);
        push_tick(1'b1, 1'b0, 2730, 1'b1);
        push_tick(1'b1, 1'b1, 1365, 1'b0);
      end

      stop_at = ticks_queued + TICKS_PER_SETTING;
      while (ticks_queued < stop_at) queue_stretch();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("maze_wall_follow_sequencer verification clean");
    end else begin
      $display("maze_wall_follow_sequencer verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("maze_wall_follow_sequencer verification failed");
    $finish;
  end

endmodule
